// ===== rtl/core/mesi_snoop_coherence_defines.svh =====
// Assertion macros for the MESI snoop coherence controller.
`ifndef MESI_SNOOP_COHERENCE_DEFINES_SVH
`define MESI_SNOOP_COHERENCE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define MESI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define MESI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mesi_pkg.sv =====
// Shared types for the MESI snoop coherence controller.
package mesi_pkg;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_st_t;

endpackage

// ===== rtl/core/mesi_snoop_coherence.sv =====
// Snooping MESI coherence controller with the line state directory in one RAM.
//
// Input channel (in_valid/in_ready): one beat per request: mode (0 access,
// 1 eviction), requesting core, read/write and line index. Line index wraps
// modulo LINES. Result channel (out_valid/out_ready): one beat per request
// with the requester's new state, the invalidate mask, and the write-back
// flag with the core that supplies the data.
// Path: directory stage, then output register. Throughput: one request per
// cycle unless the output stalls; the directory RAM is read on the input beat
// and written back as the request leaves the directory stage, and a back-to-back
// request to the same line takes the just-written entry from a bypass register.
// Reset: after rst_n the directory is swept to all-invalid, one line per cycle,
// through all LINES lines; in_ready stays low during the sweep.
// Stall: a waiting result sits in the output register; the request behind it
// holds in the directory stage and in_ready drops until out_ready frees a slot.
module mesi_snoop_coherence #(
  parameter int CORES = 4,
  parameter int LINES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [1:0]           in_requester_core,
  input  logic                 in_is_write,
  input  logic [9:0]           in_line_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_requester_state,
  output logic [3:0]           out_invalidate_mask,
  output logic                 out_writeback,
  output logic [1:0]           out_writeback_core
);
  import mesi_pkg::*;

  `include "mesi_snoop_coherence_defines.svh"

  localparam int EW  = 2 * CORES;
  localparam int LW  = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int CW  = $clog2(CORES);
  localparam int CWX = (CW > 2) ? CW : 2;
  localparam int MW  = (CORES > 4) ? CORES : 4;

  // Line index modulo LINES by restoring subtraction; quotient fits in 6 bits.
  function automatic logic [LW-1:0] line_wrap(input logic [9:0] li);
    logic [31:0] v;
    v = 32'(li);
    for (int k = 5; k >= 0; k--) begin
      if (v >= (32'(LINES) << k)) begin
        v = v - (32'(LINES) << k);
      end
    end
    return v[LW-1:0];
  endfunction

  logic [EW-1:0] dir_mem_r [LINES];
  logic [EW-1:0] rd_data_r;

  logic          clr_busy_r;
  logic [LW-1:0] clr_cnt_r;

  logic          b_valid_r;
  logic          b_mode_r;
  logic [1:0]    b_core_r;
  logic          b_wr_r;
  logic [LW-1:0] b_idx_r;
  logic          byp_r;
  logic [EW-1:0] byp_data_r;

  logic          out_valid_r;
  mesi_st_t      out_state_r;
  logic [3:0]    out_inv_r;
  logic          out_wb_r;
  logic [1:0]    out_wbc_r;

  logic          in_acc;
  logic          b_adv;
  logic          b_commit;
  logic [LW-1:0] in_idx;

  logic          core_ok;
  logic [EW-1:0] cur_e;
  logic [EW-1:0] nxt_e;
  mesi_st_t      own;
  logic          any_oth;
  logic          any_m;
  logic [CWX-1:0] m_low;
  logic [CORES-1:0] req;
  logic [CORES-1:0] oth;
  logic [MW-1:0] inv_x;
  mesi_st_t      rstate;
  logic          wb;
  logic [CWX-1:0] wbc_x;

  logic          mem_we;
  logic [LW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  assign b_adv    = !out_valid_r || out_ready;
  assign b_commit = b_valid_r && b_adv;
  assign in_ready = !clr_busy_r && (!b_valid_r || b_adv);
  assign in_acc   = in_valid && in_ready;
  assign in_idx   = line_wrap(in_line_index);

  // Directory stage: snoop the line, build the new entry and the result.
  always_comb begin
    cur_e   = byp_r ? byp_data_r : rd_data_r;
    core_ok = int'(b_core_r) < CORES;
    own     = ST_I;
    any_oth = 1'b0;
    any_m   = 1'b0;
    m_low   = '0;
    for (int i = 0; i < CORES; i++) begin
      req[i] = (int'(b_core_r) == i);
      oth[i] = !req[i] && (mesi_st_t'(cur_e[2*i +: 2]) != ST_I);
      if (req[i]) begin
        own = mesi_st_t'(cur_e[2*i +: 2]);
      end
      any_oth = any_oth | oth[i];
      any_m   = any_m | (oth[i] && (mesi_st_t'(cur_e[2*i +: 2]) == ST_M));
    end
    for (int i = CORES - 1; i >= 0; i--) begin
      if (oth[i] && (mesi_st_t'(cur_e[2*i +: 2]) == ST_M)) begin
        m_low = CWX'(i);
      end
    end

    nxt_e  = cur_e;
    inv_x  = '0;
    rstate = ST_I;
    wb     = 1'b0;
    wbc_x  = '0;
    priority if (!core_ok) begin
      rstate = ST_I;
    end else if (b_mode_r) begin
      for (int i = 0; i < CORES; i++) begin
        if (req[i]) nxt_e[2*i +: 2] = ST_I;
      end
    end else if (own != ST_I) begin
      rstate = own;
      if (b_wr_r && (own == ST_E || own == ST_S)) begin
        rstate = ST_M;
        for (int i = 0; i < CORES; i++) begin
          if (req[i]) nxt_e[2*i +: 2] = ST_M;
          if (own == ST_S && oth[i]) begin
            nxt_e[2*i +: 2] = ST_I;
            inv_x[i]        = 1'b1;
          end
        end
      end
    end else if (!b_wr_r) begin
      // read miss: every holder drops to S, a dirty holder supplies the data
      rstate = any_oth ? ST_S : ST_E;
      wb     = any_m;
      wbc_x  = any_m ? m_low : '0;
      for (int i = 0; i < CORES; i++) begin
        if (oth[i]) nxt_e[2*i +: 2] = ST_S;
        if (req[i]) nxt_e[2*i +: 2] = rstate;
      end
    end else begin
      rstate = ST_M;
      for (int i = 0; i < CORES; i++) begin
        if (req[i]) nxt_e[2*i +: 2] = ST_M;
        if (oth[i]) begin
          nxt_e[2*i +: 2] = ST_I;
          inv_x[i]        = 1'b1;
        end
      end
    end
  end

  assign mem_we    = clr_busy_r || (b_commit && core_ok);
  assign mem_waddr = clr_busy_r ? clr_cnt_r : b_idx_r;
  assign mem_wdata = clr_busy_r ? '0 : nxt_e;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dir_mem_r[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_r <= dir_mem_r[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      b_valid_r   <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LW'(LINES - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end

      if (in_acc) begin
        b_valid_r <= 1'b1;
        // entry being written this edge is newer than what the RAM returns
        byp_r     <= b_commit && core_ok && (b_idx_r == in_idx);
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end

      if (b_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_mode_r   <= in_mode;
      b_core_r   <= in_requester_core;
      b_wr_r     <= in_is_write;
      b_idx_r    <= in_idx;
      byp_data_r <= nxt_e;
    end
    if (b_commit) begin
      out_state_r <= rstate;
      out_inv_r   <= inv_x[3:0];
      out_wb_r    <= wb;
      out_wbc_r   <= wbc_x[1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_requester_state = out_state_r;
  assign out_invalidate_mask = out_inv_r;
  assign out_writeback       = out_wb_r;
  assign out_writeback_core  = out_wbc_r;

  `MESI_ASSERT_NOW(a_no_work_in_sweep, clr_busy_r, !in_acc && !b_valid_r && !out_valid_r, "request active during directory sweep")
  `MESI_ASSERT_NOW(a_inv_means_m, out_valid && (out_invalidate_mask != 4'd0), out_requester_state == ST_M, "invalidation without M grant")
  `MESI_ASSERT_NOW(a_wb_means_s, out_valid && out_writeback, out_requester_state == ST_S, "write-back without shared read")
  `MESI_ASSERT_NEXT(a_commit_shows, b_commit, out_valid_r, "committed result not in output register")

endmodule

// ===== test/coh_tb_pkg.sv =====
// Request codes shared by the coherence testbench and its checker.
package coh_tb_pkg;

  localparam logic MODE_ACCESS = 1'b0;
  localparam logic MODE_EVICT  = 1'b1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage

// ===== test/mesi_coherence_checker.sv =====
// Coherence checker: tracks the line directory, predicts each result beat and compares.
module mesi_coherence_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic       in_mode,
  input  logic [1:0] in_requester_core,
  input  logic       in_is_write,
  input  logic [9:0] in_line_index,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_requester_state,
  input  logic [3:0] out_invalidate_mask,
  input  logic       out_writeback,
  input  logic [1:0] out_writeback_core,
  output int         pending,
  output int         errors
);
  import mesi_pkg::*;
  import coh_tb_pkg::*;

  typedef struct packed {
    mesi_st_t   state;
    logic [3:0] inv;
    logic       wb;
    logic [1:0] wb_core;
  } snoop_result_t;

  // 2 bits per core, core c at bits 2c+1..2c
  logic [7:0]    line_dir [1024];
  snoop_result_t snoop_q[$];

  function automatic void snoop_update(input logic mode, input logic [1:0] core,
                                       input logic wr, inout logic [7:0] ent,
                                       output snoop_result_t r);
    mesi_st_t own;
    mesi_st_t s;
    logic     any;
    r = '0;
    any = 1'b0;
    own = mesi_st_t'(ent[2*core +: 2]);
    if (mode == MODE_EVICT) begin
      ent[2*core +: 2] = ST_I;
      r.state = ST_I;
    end else if (own != ST_I) begin
      r.state = own;
      if (wr == OP_WRITE && (own == ST_E || own == ST_S)) begin
        r.state = ST_M;
        ent[2*core +: 2] = ST_M;
        if (own == ST_S) begin
          for (int i = 0; i < 4; i++) begin
            if (i != core && mesi_st_t'(ent[2*i +: 2]) != ST_I) begin
              ent[2*i +: 2] = ST_I;
              r.inv[i] = 1'b1;
            end
          end
        end
      end
    end else if (wr == OP_READ) begin
      for (int i = 0; i < 4; i++) begin
        if (i != core) begin
          s = mesi_st_t'(ent[2*i +: 2]);
          if (s != ST_I) begin
            any = 1'b1;
            // lowest numbered M holder supplies the data
            if (s == ST_M && !r.wb) begin
              r.wb = 1'b1;
              r.wb_core = 2'(i);
            end
            ent[2*i +: 2] = ST_S;
          end
        end
      end
      r.state = any ? ST_S : ST_E;
      ent[2*core +: 2] = r.state;
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (i != core && mesi_st_t'(ent[2*i +: 2]) != ST_I) begin
          ent[2*i +: 2] = ST_I;
          r.inv[i] = 1'b1;
        end
      end
      r.state = ST_M;
      ent[2*core +: 2] = ST_M;
    end
  endfunction

  always @(posedge clk) begin : watch
    snoop_result_t want;
    snoop_result_t got;
    logic [7:0]    ent;
    logic          bad;
    if (!rst_n) begin
      for (int i = 0; i < 1024; i++) line_dir[i] = '0;
      snoop_q.delete();
      pending <= 0;
      errors  <= 0;
    end else begin
      bad = 1'b0;
      if (out_valid && out_ready) begin
        got.state   = mesi_st_t'(out_requester_state);
        got.inv     = out_invalidate_mask;
        got.wb      = out_writeback;
        got.wb_core = out_writeback_core;
        if (snoop_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: state %0d inv %h wb %b core %0d",
                   $time, got.state, got.inv, got.wb, got.wb_core);
          bad = 1'b1;
        end else begin
          want = snoop_q.pop_front();
          if (got.state != want.state) begin
            $display("%0t: requester_state expected %0d actual %0d",
                     $time, want.state, got.state);
            bad = 1'b1;
          end
          if (got.inv != want.inv) begin
            $display("%0t: invalidate_mask expected %h actual %h", $time, want.inv, got.inv);
            bad = 1'b1;
          end
          if (got.wb != want.wb) begin
            $display("%0t: writeback expected %b actual %b", $time, want.wb, got.wb);
            bad = 1'b1;
          end
          if (got.wb_core != want.wb_core) begin
            $display("%0t: writeback_core expected %0d actual %0d",
                     $time, want.wb_core, got.wb_core);
            bad = 1'b1;
          end
        end
      end
      if (in_valid && in_ready) begin
        ent = line_dir[in_line_index];
        snoop_update(in_mode, in_requester_core, in_is_write, ent, want);
        line_dir[in_line_index] = ent;
        snoop_q.insert(snoop_q.size(), want);
      end
      pending <= snoop_q.size();
      if (bad) errors <= errors + 1;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the coherence controller testbench: clock, reset, request stimulus and verdict.
module tb_top;
  import coh_tb_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_mode = MODE_ACCESS;
  logic [1:0] in_requester_core = '0;
  logic       in_is_write = OP_READ;
  logic [9:0] in_line_index = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_requester_state;
  logic [3:0] out_invalidate_mask;
  logic       out_writeback;
  logic [1:0] out_writeback_core;
  logic       calm = 1'b0;
  int         pending;
  int         errors;
  logic [9:0] hot_lines [8];

  always #5 clk = ~clk;

  mesi_snoop_coherence i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_requester_core   (in_requester_core),
    .in_is_write         (in_is_write),
    .in_line_index       (in_line_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_requester_state (out_requester_state),
    .out_invalidate_mask (out_invalidate_mask),
    .out_writeback       (out_writeback),
    .out_writeback_core  (out_writeback_core)
  );

  mesi_coherence_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_requester_core   (in_requester_core),
    .in_is_write         (in_is_write),
    .in_line_index       (in_line_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_requester_state (out_requester_state),
    .out_invalidate_mask (out_invalidate_mask),
    .out_writeback       (out_writeback),
    .out_writeback_core  (out_writeback_core),
    .pending             (pending),
    .errors              (errors)
  );

  always @(posedge clk) begin
    if (calm) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(99) >= 21);
  end

  task automatic send_req(input logic mode, input logic [1:0] core, input logic wr,
                          input logic [9:0] line);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_mode           <= mode;
    in_requester_core <= core;
    in_is_write       <= wr;
    in_line_index     <= line;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender off until the directory pipeline has drained
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic       mode;
    logic [9:0] line;
    for (int i = 0; i < 8; i++) hot_lines[i] = 10'($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // hand-built sharing sequences on line 0, line 1023 and alternating bit patterns
    send_req(MODE_ACCESS, 2'd0, OP_READ,  10'd0);
    send_req(MODE_ACCESS, 2'd0, OP_READ,  10'd0);
    send_req(MODE_ACCESS, 2'd0, OP_WRITE, 10'd0);
    send_req(MODE_ACCESS, 2'd0, OP_WRITE, 10'd0);
    send_req(MODE_ACCESS, 2'd1, OP_READ,  10'd0);
    send_req(MODE_ACCESS, 2'd2, OP_READ,  10'd0);
    send_req(MODE_ACCESS, 2'd1, OP_WRITE, 10'd0);
    send_req(MODE_ACCESS, 2'd3, OP_READ,  10'd0);
    send_req(MODE_EVICT,  2'd3, OP_WRITE, 10'd0);
    send_req(MODE_ACCESS, 2'd2, OP_WRITE, 10'd0);
    send_req(MODE_EVICT,  2'd2, OP_READ,  10'd0);
    send_req(MODE_EVICT,  2'd0, OP_READ,  10'd0);
    send_req(MODE_ACCESS, 2'd3, OP_WRITE, 10'd1023);
    send_req(MODE_ACCESS, 2'd3, OP_READ,  10'd1023);
    send_req(MODE_ACCESS, 2'd0, OP_WRITE, 10'd1023);
    send_req(MODE_ACCESS, 2'd1, OP_READ,  10'd1023);
    send_req(MODE_ACCESS, 2'd2, OP_READ,  10'd1023);
    send_req(MODE_ACCESS, 2'd3, OP_READ,  10'd1023);
    send_req(MODE_ACCESS, 2'd3, OP_WRITE, 10'd1023);
    send_req(MODE_ACCESS, 2'd0, OP_READ,  10'h2AA);
    send_req(MODE_ACCESS, 2'd1, OP_READ,  10'h155);
    send_req(MODE_ACCESS, 2'd1, OP_WRITE, 10'h155);
    send_req(MODE_EVICT,  2'd0, OP_READ,  10'h2AA);
    drain_results();

    // mostly a few hot lines so states build up, some scattered lines
    for (int k = 0; k < 530; k++) begin
      if (k == 150) calm <= 1'b1;
      if (k == 300) calm <= 1'b0;
      if (k == 400) drain_results();
      mode = ($urandom_range(99) < 15) ? MODE_EVICT : MODE_ACCESS;
      if ($urandom_range(99) < 80) line = hot_lines[$urandom_range(7)];
      else line = 10'($urandom);
      send_req(mode, 2'($urandom_range(3)), 1'($urandom_range(1)), line);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mesi_pkg.sv
rtl/core/mesi_snoop_coherence.sv
test/coh_tb_pkg.sv
test/mesi_coherence_checker.sv
test/tb_top.sv
